// ===== sv/spwm_pkg.sv =====
// Shared constants, types, and sine quarter-wave table for the sine PWM duty core.
`timescale 1ns / 1ps

package spwm_pkg;

   // Block configuration
   localparam int PHASE_BITS         = 32;
   localparam int SINE_TABLE_ENTRIES = 512;
   localparam int DUTY_MID           = 32768;

   // Port widths
   localparam int STEP_BITS = 32;
   localparam int DUTY_BITS = 16;
   localparam logic [STEP_BITS-1:0] STEP_RESET = 32'd107374;

   // Lookup geometry
   localparam int FRAC_BITS = 16;
   localparam int IDX_BITS  = $clog2(SINE_TABLE_ENTRIES);
   localparam int K_BITS    = IDX_BITS + 1;
   localparam int QUARTER   = SINE_TABLE_ENTRIES / 4;
   localparam int Q_BITS    = $clog2(QUARTER + 1);

   // Datapath widths
   localparam int SINE_BITS   = 32;                              // signed Q1.30
   localparam int DIFF_BITS   = SINE_BITS + 1;
   localparam int IPROD_BITS  = DIFF_BITS + FRAC_BITS + 1;
   localparam int V_BITS      = 48;                              // signed Q1.46
   localparam int MAG_BITS    = 47;
   localparam int SCALE_BITS  = $clog2(DUTY_MID);
   localparam int PROD_BITS   = MAG_BITS + SCALE_BITS + 1;
   localparam int ROUND_SHIFT = 46;
   localparam int R_BITS      = PROD_BITS - ROUND_SHIFT;

   typedef logic [SINE_BITS-2:0] sine_mag_type;
   typedef sine_mag_type sine_quarter_type [0:QUARTER];

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_READ_LO,
      ST_READ_HI,
      ST_DIFF,
      ST_INTERP,
      ST_ABS,
      ST_SCALE,
      ST_OUT
   } spwm_state_type;

   typedef struct packed {
      logic accumulate;
      logic read_lo;
      logic read_hi;
      logic take_diff;
      logic interp;
      logic take_abs;
      logic scale;
      logic load_out;
   } spwm_cmd_type;

   typedef struct packed {
      logic out_free;
   } spwm_status_type;

   // Elaboration-time table build: integer Taylor series of sin on [0, pi/2]
   localparam logic [63:0] PI_Q30      = 64'd3373259426;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
   localparam logic [63:0] TaylorDiv1  = 64'd6;
   localparam logic [63:0] TaylorDiv2  = 64'd20;
   localparam logic [63:0] TaylorDiv3  = 64'd42;
   localparam logic [63:0] TaylorDiv4  = 64'd72;
   localparam logic [63:0] TaylorDiv5  = 64'd110;
   localparam logic [63:0] TaylorDiv6  = 64'd156;
   localparam logic [63:0] TaylorDiv7  = 64'd210;
   localparam logic [63:0] TableCount  = 64'(SINE_TABLE_ENTRIES);

   function automatic logic [63:0] taylor_raise(input logic [63:0] term, input logic [63:0] x);
      logic [63:0] t;
      t = (term * x) >> 30;
      t = (t * x) >> 30;
      return t;
   endfunction

   function automatic sine_mag_type sin_first_quadrant(input logic [63:0] x);
      logic [63:0]        term;
      logic signed [63:0] sum;
      term = x;
      sum  = $signed(x);
      term = taylor_raise(term, x) / TaylorDiv1;  sum = sum - $signed(term);
      term = taylor_raise(term, x) / TaylorDiv2;  sum = sum + $signed(term);
      term = taylor_raise(term, x) / TaylorDiv3;  sum = sum - $signed(term);
      term = taylor_raise(term, x) / TaylorDiv4;  sum = sum + $signed(term);
      term = taylor_raise(term, x) / TaylorDiv5;  sum = sum - $signed(term);
      term = taylor_raise(term, x) / TaylorDiv6;  sum = sum + $signed(term);
      term = taylor_raise(term, x) / TaylorDiv7;  sum = sum - $signed(term);
      if (sum > $signed(ONE_Q30)) begin
         sum = $signed(ONE_Q30);
      end
      if (sum < 0) begin
         sum = 0;
      end
      return sine_mag_type'(sum);
   endfunction

   function automatic sine_quarter_type build_sine_quarter();
      sine_quarter_type tab;
      for (int q = 0; q <= QUARTER; q++) begin
         tab[q] = sin_first_quadrant((PI_Q30 * (64'd2 * 64'(q))) / TableCount);
      end
      return tab;
   endfunction

   localparam sine_quarter_type SINE_QUARTER = build_sine_quarter();

endpackage

// ===== sv/spwm_ctrl.sv =====
// Sequencer for the sine PWM duty core: steps one tick through the datapath.
`timescale 1ns / 1ps

module spwm_ctrl
   import spwm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_tick,
   output logic            req_ready,
   input  spwm_status_type status,
   output spwm_cmd_type    cmd
);

   spwm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            // a word with tick low moves nothing
            if (req_valid && req_tick) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            cmd.accumulate = 1'b1;
            state_in       = ST_READ_LO;
         end
         ST_READ_LO: begin
            cmd.read_lo = 1'b1;
            state_in    = ST_READ_HI;
         end
         ST_READ_HI: begin
            cmd.read_hi = 1'b1;
            state_in    = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.take_diff = 1'b1;
            state_in      = ST_INTERP;
         end
         ST_INTERP: begin
            cmd.interp = 1'b1;
            state_in   = ST_ABS;
         end
         ST_ABS: begin
            cmd.take_abs = 1'b1;
            state_in     = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/spwm_dpath.sv =====
// Datapath of the sine PWM duty core: phase, table interpolation, scaling, output register.
`timescale 1ns / 1ps

module spwm_dpath
   import spwm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  spwm_cmd_type         cmd,
   output spwm_status_type      status,
   input  logic                 csr_write_enable,
   input  logic [STEP_BITS-1:0] csr_write_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [DUTY_BITS-1:0] rsp_duty_high_side,
   output logic [DUTY_BITS-1:0] rsp_duty_low_side
);

   localparam logic [K_BITS-1:0]    K_Q1     = K_BITS'(QUARTER);
   localparam logic [K_BITS-1:0]    K_Q2     = K_BITS'(2 * QUARTER);
   localparam logic [K_BITS-1:0]    K_Q3     = K_BITS'(3 * QUARTER);
   localparam logic [K_BITS-1:0]    K_Q4     = K_BITS'(SINE_TABLE_ENTRIES);
   localparam logic [R_BITS-1:0]    R_MAX    = R_BITS'(DUTY_MID - 1);
   localparam logic [DUTY_BITS-1:0] MID      = DUTY_BITS'(DUTY_MID);
   localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (ROUND_SHIFT - 1);

   // control-side registers
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic signed [SINE_BITS-1:0] t0_ff, t0_in;
   logic signed [SINE_BITS-1:0] t1_ff, t1_in;
   logic signed [DIFF_BITS-1:0] diff_ff, diff_in;
   logic signed [V_BITS-1:0]    v_ff, v_in;
   logic                        neg_ff, neg_in;
   logic [MAG_BITS-1:0]         mag_ff, mag_in;
   logic [PROD_BITS-1:0]        prod_ff, prod_in;
   logic [DUTY_BITS-1:0]        high_ff, high_in;
   logic [DUTY_BITS-1:0]        low_ff, low_in;

   // lookup path
   logic [IDX_BITS-1:0]         idx;
   logic [PHASE_BITS-1:0]       frac_full;
   logic [FRAC_BITS-1:0]        frac;
   logic [K_BITS-1:0]           k;
   logic [Q_BITS-1:0]           q;
   logic                        q_neg;
   logic signed [SINE_BITS-1:0] t_mag;
   logic signed [SINE_BITS-1:0] t_sel;

   // interpolation and rounding
   logic signed [IPROD_BITS-1:0] interp_prod;
   logic signed [IPROD_BITS-1:0] interp_base;
   logic [R_BITS-1:0]            r_raw;
   logic [R_BITS-1:0]            r_sat;
   logic [DUTY_BITS-1:0]         s_mag;

   assign idx       = phase_ff[PHASE_BITS-1 -: IDX_BITS];
   assign frac_full = {phase_ff[PHASE_BITS-IDX_BITS-1:0], {IDX_BITS{1'b0}}};
   assign frac      = frac_full[PHASE_BITS-1 -: FRAC_BITS];
   assign k         = cmd.read_hi ? (K_BITS'(idx) + K_BITS'(1)) : K_BITS'(idx);

   // fold the full-wave index onto the quarter-wave table
   always_comb begin
      if (k <= K_Q1) begin
         q     = Q_BITS'(k);
         q_neg = 1'b0;
      end else if (k <= K_Q2) begin
         q     = Q_BITS'(K_Q2 - k);
         q_neg = 1'b0;
      end else if (k <= K_Q3) begin
         q     = Q_BITS'(k - K_Q2);
         q_neg = 1'b1;
      end else if (k == K_Q4) begin
         q     = '0;
         q_neg = 1'b0;
      end else begin
         q     = Q_BITS'(K_Q4 - k);
         q_neg = 1'b1;
      end
   end

   assign t_mag = $signed(SINE_BITS'(SINE_QUARTER[q]));
   assign t_sel = q_neg ? -t_mag : t_mag;

   assign interp_prod = diff_ff * $signed({1'b0, frac});
   assign interp_base = {{(IPROD_BITS-SINE_BITS-FRAC_BITS){t0_ff[SINE_BITS-1]}},
                         t0_ff, {FRAC_BITS{1'b0}}};

   assign r_raw = prod_ff[PROD_BITS-1:ROUND_SHIFT];
   assign r_sat = (r_raw > R_MAX) ? R_MAX : r_raw;
   assign s_mag = DUTY_BITS'(r_sat);

   always_comb begin
      step_in      = csr_write_enable ? csr_write_data : step_ff;
      phase_in     = cmd.accumulate ? (phase_ff + PHASE_BITS'(step_ff)) : phase_ff;
      rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

      t0_in   = cmd.read_lo   ? t_sel : t0_ff;
      t1_in   = cmd.read_hi   ? t_sel : t1_ff;
      diff_in = cmd.take_diff ? (DIFF_BITS'(t1_ff) - DIFF_BITS'(t0_ff)) : diff_ff;
      v_in    = cmd.interp    ? V_BITS'(interp_base + interp_prod) : v_ff;
      neg_in  = cmd.take_abs  ? v_ff[V_BITS-1] : neg_ff;
      mag_in  = cmd.take_abs  ? MAG_BITS'(v_ff[V_BITS-1] ? -v_ff : v_ff) : mag_ff;
      prod_in = cmd.scale
                ? (PROD_BITS'(mag_ff) * PROD_BITS'(DUTY_MID - 1) + ROUND_HALF)
                : prod_ff;
      high_in = cmd.load_out ? (neg_ff ? (MID - s_mag) : (MID + s_mag)) : high_ff;
      low_in  = cmd.load_out ? (neg_ff ? (MID + s_mag) : (MID - s_mag)) : low_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_RESET;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t0_ff   <= t0_in;
      t1_ff   <= t1_in;
      diff_ff <= diff_in;
      v_ff    <= v_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      prod_ff <= prod_in;
      high_ff <= high_in;
      low_ff  <= low_in;
   end

   assign status.out_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_duty_high_side = high_ff;
   assign rsp_duty_low_side  = low_ff;

endmodule

// ===== sv/sine_pwm_complementary_duty_core.sv =====
// Top level of the sine PWM duty core: sequencer plus datapath.
`timescale 1ns / 1ps
//
// One request word per PWM period. A word with req_tick high advances the
// phase accumulator by the configured phase step, looks up the sine of the
// new phase (quarter-wave table, linear interpolation between neighbors),
// scales it to DUTY_MID-1 with rounding and returns the pair
// DUTY_MID + s / DUTY_MID - s as one response word for a bridge leg.
// A word with req_tick low is taken and dropped: no phase change, no response.
//
// The sequencer walks the phase update, both table reads, the interpolation
// multiply and the scale multiply one step per cycle, stalling only at the
// final load; it takes no new tick word before it is through with the last.
// req_ready is high only while the sequencer is idle.
//
// The response sits in an output register; a stalled receiver holds it there
// while the next tick is already taken and computed. Only the final load
// waits for the register to free up.
//
// Reset (synchronous, active high): phase goes to zero, the phase step to its
// default, the output register empties. csr_write_enable loads the step at once.
//
module sine_pwm_complementary_duty_core
   import spwm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_tick,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DUTY_BITS-1:0] rsp_duty_high_side,
   output logic [DUTY_BITS-1:0] rsp_duty_low_side,
   // phase step register
   input  logic                 csr_write_enable,
   input  logic [STEP_BITS-1:0] csr_write_data
);

   spwm_cmd_type    cmd;
   spwm_status_type status;

   // sequencer: one step of the tick computation per state
   spwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_tick  (req_tick),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // phase accumulator, table, interpolation, scaling, output register
   spwm_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_duty_high_side (rsp_duty_high_side),
      .rsp_duty_low_side  (rsp_duty_low_side)
   );

endmodule

// ===== sv/spwm_checker.sv =====
// Port-level checks for the sine PWM duty core, bound to the top level.
`timescale 1ns / 1ps

module spwm_checker
   import spwm_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 req_tick,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [DUTY_BITS-1:0] rsp_duty_high_side,
   input logic [DUTY_BITS-1:0] rsp_duty_low_side
);

   // complementary pair always sums to twice the midpoint
   a_duty_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (DUTY_BITS'(rsp_duty_high_side + rsp_duty_low_side)
                     == DUTY_BITS'(2 * DUTY_MID)))
      else $error("duty pair not complementary");

   // a tick word starts work, so the request side closes the next cycle
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_tick) |=> !req_ready)
      else $error("request taken during tick processing");

   // a word without tick is dropped and the block stays open
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_tick) |=> req_ready)
      else $error("empty tick blocked the request side");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_duty_high_side)
                                     && $stable(rsp_duty_low_side)))
      else $error("stalled response changed");

endmodule

bind sine_pwm_complementary_duty_core spwm_checker u_spwm_checker (.*);

// ===== bench/tb.sv =====
// Self-checking testbench for the sine PWM complementary duty core.
`timescale 1ns / 1ps

module tb;
   import spwm_pkg::*;

   // Run shape
   localparam int     RANDOM_TICKS  = 1500;
   localparam int     SETTLE_CYCLES = 12;          // settle time after the queue drains
   localparam longint TIMEOUT_NS    = 20_000_000;  // simulation time limit in ns

   // pi in Q2.30, used to build the sine lookup on our side
   localparam logic [63:0] HALF_TURN_Q30 = 64'd3373259426;
   localparam longint      UNIT_Q30      = 64'sd1 << 30;

   // Receiver stall patterns
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_LONG
   } stall_mode_type;

   typedef struct packed {
      logic [DUTY_BITS-1:0] high_side;
      logic [DUTY_BITS-1:0] low_side;
   } duty_pair_type;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic                 req_tick         = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [DUTY_BITS-1:0] rsp_duty_high_side;
   logic [DUTY_BITS-1:0] rsp_duty_low_side;
   logic                 csr_write_enable = 1'b0;
   logic [STEP_BITS-1:0] csr_write_data   = '0;

   // Our copy of the block state and its phase step register
   longint               sine_ref [0:SINE_TABLE_ENTRIES];
   logic [PHASE_BITS-1:0] phase_now    = '0;
   logic [STEP_BITS-1:0]  step_setting = STEP_RESET;

   // Duty pairs still owed by the block, oldest first
   duty_pair_type duty_queue [$];

   int error_count  = 0;
   int rsp_count    = 0;
   int burst_left   = 0;

   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left  = 0;
   int             hold_left  = 0;

   sine_pwm_complementary_duty_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_tick           (req_tick),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_duty_high_side (rsp_duty_high_side),
      .rsp_duty_low_side  (rsp_duty_low_side),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard stop in case the block hangs
   initial begin
      #(TIMEOUT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   //--------------------------------------------------------------------------
   // Prediction
   //--------------------------------------------------------------------------

   // sin(angle) for angle in Q2.30 on [0, pi/2]: Taylor series to x^15 with
   // truncating shifts and divides, clamped to [0, 1.0] in Q1.30.
   function automatic longint quadrant_sine(input logic [63:0] angle);
      logic [63:0] power;
      longint      acc;
      power = angle;
      acc   = longint'(angle);
      for (int n = 1; n <= 7; n++) begin
         power = (power * angle) >> 30;
         power = (power * angle) >> 30;
         power = power / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - longint'(power);
         end else begin
            acc = acc + longint'(power);
         end
      end
      if (acc > UNIT_Q30) begin
         acc = UNIT_Q30;
      end
      if (acc < 0) begin
         acc = 0;
      end
      return acc;
   endfunction

   // Duty pair for a phase: top IDX_BITS pick the entry, the next 16 bits
   // interpolate toward its neighbor (Q1.46), then scale by DUTY_MID-1 and
   // round half away from zero.
   function automatic duty_pair_type duty_for_phase(input logic [PHASE_BITS-1:0] phase);
      int unsigned          ix;
      logic [FRAC_BITS-1:0] frac;
      longint               base;
      longint               slope;
      longint               level;
      longint               swing;
      logic [63:0]          mag;
      logic [63:0]          scaled;
      duty_pair_type        pair;
      ix     = phase[PHASE_BITS-1 -: IDX_BITS];
      frac   = phase[PHASE_BITS-IDX_BITS-1 -: FRAC_BITS];
      base   = sine_ref[ix];
      slope  = sine_ref[ix + 1] - base;
      level  = base * 65536 + slope * longint'(frac);
      mag    = (level < 0) ? 64'(-level) : 64'(level);
      scaled = (mag * 64'(DUTY_MID - 1) + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
      if (scaled > 64'(DUTY_MID - 1)) begin
         scaled = 64'(DUTY_MID - 1);
      end
      swing  = (level < 0) ? -longint'(scaled) : longint'(scaled);
      pair.high_side = DUTY_BITS'(longint'(DUTY_MID) + swing);
      pair.low_side  = DUTY_BITS'(longint'(DUTY_MID) - swing);
      return pair;
   endfunction

   //--------------------------------------------------------------------------
   // Checking
   //--------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      error_count++;
      $display("ERROR @%0t: %s", $realtime, what);
   endtask

   // Compare each accepted response word with the oldest pending duty pair
   always @(posedge clock) begin
      duty_pair_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (duty_queue.size() == 0) begin
            report_mismatch($sformatf("response %0d with no tick pending (%0d/%0d)",
                                      rsp_count, rsp_duty_high_side, rsp_duty_low_side));
         end else begin
            want = duty_queue.pop_front();
            if (rsp_duty_high_side !== want.high_side) begin
               report_mismatch($sformatf("response %0d high side %0d, want %0d",
                                         rsp_count, rsp_duty_high_side, want.high_side));
            end
            if (rsp_duty_low_side !== want.low_side) begin
               report_mismatch($sformatf("response %0d low side %0d, want %0d",
                                         rsp_count, rsp_duty_low_side, want.low_side));
            end
         end
      end
   end

   // Receiver: pick a new stall pattern whenever the current one runs out.
   // Long mode holds ready low for longer random stretches than high, so the output register
   // backs up while the next tick is already in flight.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(50, 400);
      end
      mode_left--;
      case (stall_mode)
         STALL_NONE: begin
            rsp_ready = 1'b1;
         end
         STALL_LIGHT: begin
            rsp_ready = ($urandom_range(0, 3) != 0);
         end
         STALL_HEAVY: begin
            rsp_ready = ($urandom_range(0, 3) == 0);
         end
         default: begin
            if (hold_left == 0) begin
               rsp_ready = !rsp_ready;
               hold_left = rsp_ready ? $urandom_range(1, 4) : $urandom_range(5, 30);
            end else begin
               hold_left--;
            end
         end
      endcase
   end

   //--------------------------------------------------------------------------
   // Stimulus helpers
   //--------------------------------------------------------------------------

   // Offer one request word and hold it until taken. Valid is left high so a
   // following word goes out with no gap; callers that pause drop it first.
   task automatic send_tick(input logic tick_bit);
      @(negedge clock);
      req_valid = 1'b1;
      req_tick  = tick_bit;
      do begin
         @(posedge clock);
      end while (!req_ready);
      // A low tick is dropped by the block: phase holds, nothing comes back
      if (tick_bit) begin
         phase_now = phase_now + PHASE_BITS'(step_setting);
         duty_queue.push_back(duty_for_phase(phase_now));
      end
   endtask

   // Sender pacing: bursts of random length, most of them preceded by a gap
   task automatic paced_tick(input logic tick_bit);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            req_tick  = 1'($urandom);
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
      burst_left--;
      send_tick(tick_bit);
   endtask

   // Drop valid, wait for every owed response, then let the sequencer settle
   // in case the last word taken was a dropped low tick.
   task automatic wait_for_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (duty_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the phase step while the block is idle
   task automatic program_step(input logic [STEP_BITS-1:0] value);
      wait_for_results();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      step_setting     = value;
   endtask

   //--------------------------------------------------------------------------
   // Tests
   //--------------------------------------------------------------------------

   // Default step straight out of reset, with a dropped low tick in between
   task automatic test_reset_step();
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
   endtask

   // Land the phase on the sine's peaks, trough, zero crossings, the very
   // top of the table and the wrap back to zero; zero and all-ones steps.
   task automatic test_phase_extremes();
      program_step('0);                               // phase must hold
      send_tick(1'b1);
      send_tick(1'b1);
      program_step(32'h4000_0000 - phase_now);        // positive peak
      send_tick(1'b1);
      program_step(32'h8000_0000);                    // trough, then peak again
      send_tick(1'b1);
      send_tick(1'b1);
      program_step(32'h8000_0000 - phase_now);        // zero crossing at half turn
      send_tick(1'b1);
      program_step(32'hFFFF_FFFF - phase_now);        // last entry, full fraction
      send_tick(1'b1);
      program_step(32'h0000_0001);                    // wrap to zero, low tick, creep
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      program_step(32'hFFFF_FFFF);                    // run backward through zero
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
   endtask

   // Phases with a fresh step each: slow sweeps, arbitrary steps, backward
   // sweeps and near-half-turn steps; about one word in ten is a low tick.
   task automatic test_random_ticks();
      logic [STEP_BITS-1:0] step_pick;
      int                   sent;
      int                   run_len;
      sent = 0;
      while (sent < RANDOM_TICKS) begin
         case ($urandom_range(0, 3))
            0:       step_pick = STEP_BITS'($urandom_range(1, 1 << 20));
            1:       step_pick = STEP_BITS'($urandom);
            2:       step_pick = 32'hFFFF_FFFF - STEP_BITS'($urandom_range(0, 1 << 16));
            default: step_pick = 32'h8000_0000 ^ STEP_BITS'($urandom_range(0, 1 << 12));
         endcase
         program_step(step_pick);
         run_len = $urandom_range(60, 200);
         for (int i = 0; i < run_len; i++) begin
            // now and then hold off mid-run until the pipeline is empty
            if (i == run_len / 2 && $urandom_range(0, 1) == 1) begin
               wait_for_results();
            end
            paced_tick($urandom_range(0, 9) != 0);
            sent++;
         end
      end
   endtask

   //--------------------------------------------------------------------------
   // Main sequence
   //--------------------------------------------------------------------------

   initial begin
      int          fold;
      int          kk;
      logic        negate;
      logic [63:0] angle;
      // Full-wave sine lookup in Q1.30 plus the wrap entry, folded into the
      // first quadrant
      for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
         kk = (k == SINE_TABLE_ENTRIES) ? 0 : k;
         if (4 * kk <= SINE_TABLE_ENTRIES) begin
            fold = 2 * kk;
            negate = 1'b0;
         end else if (4 * kk <= 2 * SINE_TABLE_ENTRIES) begin
            fold = SINE_TABLE_ENTRIES - 2 * kk;
            negate = 1'b0;
         end else if (4 * kk <= 3 * SINE_TABLE_ENTRIES) begin
            fold = 2 * kk - SINE_TABLE_ENTRIES;
            negate = 1'b1;
         end else begin
            fold = 2 * SINE_TABLE_ENTRIES - 2 * kk;
            negate = 1'b1;
         end
         angle = (HALF_TURN_Q30 * 64'(fold)) / 64'(SINE_TABLE_ENTRIES);
         sine_ref[k] = negate ? -quadrant_sine(angle) : quadrant_sine(angle);
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_step();
      test_phase_extremes();
      test_random_ticks();

      wait_for_results();
      if (duty_queue.size() != 0) begin
         report_mismatch($sformatf("%0d duty pairs never returned", duty_queue.size()));
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/spwm_pkg.sv
sv/spwm_ctrl.sv
sv/spwm_dpath.sv
sv/sine_pwm_complementary_duty_core.sv
sv/spwm_checker.sv
bench/tb.sv
